FILE: sv/thci_pkg.sv
// thci_pkg: shared types and constants for the two-hand control interlock
// phase encoding, register indexes, field widths and register reset values
// no dependencies
package thci_pkg;

  localparam int unsigned MsW      = 16;
  localparam int unsigned PreW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PhaseW   = 2;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegWindowMs    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRunMs       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMsPrescale  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAlarmOn     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAlarmPeriod = 3'd4;

  // register reset values
  localparam logic [MsW-1:0]  WindowMsRst    = 16'd250;
  localparam logic [MsW-1:0]  RunMsRst       = 16'd5000;
  localparam logic [PreW-1:0] MsPrescaleRst  = 8'd10;
  localparam logic [MsW-1:0]  AlarmOnRst     = 16'd2500;
  localparam logic [MsW-1:0]  AlarmPeriodRst = 16'd5000;

  // reported phase codes
  localparam logic [PhaseW-1:0] PhaseCodeIdle   = 2'd0;
  localparam logic [PhaseW-1:0] PhaseCodeWindow = 2'd1;
  localparam logic [PhaseW-1:0] PhaseCodeRun    = 2'd2;
  localparam logic [PhaseW-1:0] PhaseCodeAlarm  = 2'd3;

  typedef enum logic [3:0] {
    PhIdle   = 4'b0001,
    PhWindow = 4'b0010,
    PhRun    = 4'b0100,
    PhAlarm  = 4'b1000
  } phase_e;

endpackage

FILE: sv/two_hand_control_interlock.sv
// two_hand_control_interlock: top level of the two-hand safety start control
// phase machine, ms prescaler, window/run/alarm counters and result register
// depends on thci_pkg
//
// Each input transaction is one 100 us tick carrying the sampled button states; each
// tick produces exactly one result transaction with the motor, lamp, buzzer and phase
// after that tick. The block takes one tick per clock: the whole next-state update is
// a single pass of short logic from the phase/counter registers into the result
// register, and a new tick is accepted whenever the result register is empty or being
// drained in the same cycle, so a stalled output holds the input only while its one
// result register is full. Configuration writes are accepted in every cycle and act
// from the next tick on; write them only while no tick is in flight.
module two_hand_control_interlock (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input ticks
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] start_one_pressed,
                                                       // [1] start_two_pressed,
                                                       // [2] emergency_pressed
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [0] motor_on, [1] lamp_on,
                                                       // [2] buzzer_level,
                                                       // [4:3] phase_now
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [thci_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [thci_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [thci_pkg::MsW-1:0]  window_ms_q, run_ms_q, alarm_on_q, alarm_period_q;
  logic [thci_pkg::PreW-1:0] ms_prescale_q;

  thci_pkg::phase_e          phase_q, phase_d;
  logic [thci_pkg::PreW-1:0] pre_q, pre_d;
  logic [thci_pkg::MsW-1:0]  ms_q, ms_d;
  logic [thci_pkg::MsW-1:0]  alarm_q, alarm_d;
  logic                      buzz_q, buzz_d;

  logic                      out_valid_q;
  logic [7:0]                out_data_q;
  logic [7:0]                out_data_d;

  logic                      in_fire;
  logic                      s1, s2, em, any_held, both_held;
  logic [thci_pkg::PreW-1:0] pre_lim;
  logic [thci_pkg::PreW:0]   pre_inc;
  logic [thci_pkg::PreW-1:0] pre_adv;
  logic [thci_pkg::MsW-1:0]  ms_inc;
  logic [thci_pkg::MsW-1:0]  alarm_inc;
  logic [thci_pkg::PhaseW-1:0] phase_code;
  logic                      run_now;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign s1        = s_axis_tdata[0];
  assign s2        = s_axis_tdata[1];
  assign em        = s_axis_tdata[2];
  assign any_held  = s1 || s2;
  assign both_held = s1 && s2;

  // prescale of zero behaves as one
  assign pre_lim = (ms_prescale_q == '0) ? thci_pkg::PreW'(1) : ms_prescale_q;
  assign pre_inc = {1'b0, pre_q} + (thci_pkg::PreW+1)'(1);
  assign pre_adv = (pre_inc >= {1'b0, pre_lim}) ? '0 : pre_inc[thci_pkg::PreW-1:0];
  assign ms_inc  = ms_q + thci_pkg::MsW'(1);
  assign alarm_inc = alarm_q + thci_pkg::MsW'(1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms_q    <= thci_pkg::WindowMsRst;
      run_ms_q       <= thci_pkg::RunMsRst;
      ms_prescale_q  <= thci_pkg::MsPrescaleRst;
      alarm_on_q     <= thci_pkg::AlarmOnRst;
      alarm_period_q <= thci_pkg::AlarmPeriodRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        thci_pkg::RegWindowMs:    window_ms_q    <= cfg_data_i;
        thci_pkg::RegRunMs:       run_ms_q       <= cfg_data_i;
        thci_pkg::RegMsPrescale:  ms_prescale_q  <= cfg_data_i[thci_pkg::PreW-1:0];
        thci_pkg::RegAlarmOn:     alarm_on_q     <= cfg_data_i;
        thci_pkg::RegAlarmPeriod: alarm_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state for one tick
  always_comb begin
    phase_d = phase_q;
    pre_d   = pre_q;
    ms_d    = ms_q;
    alarm_d = alarm_q;
    buzz_d  = buzz_q;
    unique case (phase_q)
      thci_pkg::PhIdle: begin
        buzz_d = 1'b0;
        if (any_held) begin
          phase_d = thci_pkg::PhWindow;
          ms_d    = '0;
          pre_d   = '0;
        end
      end
      thci_pkg::PhWindow, thci_pkg::PhRun: begin
        if (pre_q == '0) begin
          if ((phase_q == thci_pkg::PhWindow && ms_q >= window_ms_q) ||
              (phase_q == thci_pkg::PhRun && (ms_q >= run_ms_q || em))) begin
            // timeout or end of run
            phase_d = any_held ? thci_pkg::PhAlarm : thci_pkg::PhIdle;
            alarm_d = '0;
            buzz_d  = 1'b0;
            pre_d   = '0;
            ms_d    = '0;
          end else if (phase_q == thci_pkg::PhWindow && both_held) begin
            phase_d = thci_pkg::PhRun;
            ms_d    = '0;
            pre_d   = '0;
          end else begin
            ms_d  = ms_inc;
            pre_d = pre_adv;
          end
        end else begin
          pre_d = pre_adv;
        end
      end
      thci_pkg::PhAlarm: begin
        if (!any_held) begin
          phase_d = thci_pkg::PhIdle;
          buzz_d  = 1'b0;
          alarm_d = '0;
        end else begin
          buzz_d  = (alarm_q < alarm_on_q) ? !buzz_q : 1'b0;
          // zero period wraps naturally at the counter width
          alarm_d = (alarm_period_q != '0 && alarm_inc >= alarm_period_q) ? '0 : alarm_inc;
        end
      end
      default: begin
        phase_d = thci_pkg::PhIdle;
        buzz_d  = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (phase_d)
      thci_pkg::PhIdle:   phase_code = thci_pkg::PhaseCodeIdle;
      thci_pkg::PhWindow: phase_code = thci_pkg::PhaseCodeWindow;
      thci_pkg::PhRun:    phase_code = thci_pkg::PhaseCodeRun;
      thci_pkg::PhAlarm:  phase_code = thci_pkg::PhaseCodeAlarm;
      default:            phase_code = thci_pkg::PhaseCodeIdle;
    endcase
  end

  assign run_now    = (phase_d == thci_pkg::PhRun);
  assign out_data_d = {3'b000, phase_code, buzz_d, run_now, run_now};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= thci_pkg::PhIdle;
      pre_q   <= '0;
      ms_q    <= '0;
      alarm_q <= '0;
      buzz_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      pre_q   <= pre_d;
      ms_q    <= ms_d;
      alarm_q <= alarm_d;
      buzz_q  <= buzz_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: bench/tb_two_hand_control_interlock.sv
// tb_two_hand_control_interlock: self-checking bench for the two-hand control interlock
// streams button ticks, predicts phase, motor, lamp and buzzer per tick and checks each result
// depends on thci_pkg and two_hand_control_interlock
`timescale 1ns / 100ps

module tb_two_hand_control_interlock;
  import thci_pkg::*;

  localparam int NumSettings = 7;
  localparam int TicksPerSetting = 100;
  localparam int HoldCycles = 250;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              buzzer;
    logic              lamp;
    logic              motor;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // button ticks waiting to be sent, {emergency, start two, start one}
  logic [2:0] tick_q[$];
  outcome_t   outcome_q[$];

  // register copy used for prediction
  logic [MsW-1:0]  set_window   = WindowMsRst;
  logic [MsW-1:0]  set_run      = RunMsRst;
  logic [PreW-1:0] set_prescale = MsPrescaleRst;
  logic [MsW-1:0]  set_alarm_on = AlarmOnRst;
  logic [MsW-1:0]  set_period   = AlarmPeriodRst;

  // interlock state as predicted
  logic [PhaseW-1:0] ilk_phase = PhaseCodeIdle;
  logic [PreW-1:0]   ilk_pre   = '0;
  logic [MsW-1:0]    ilk_ms    = '0;
  logic [MsW-1:0]    ilk_alarm = '0;
  logic              ilk_buzz  = 1'b0;

  int unsigned fault_count = 0;
  int unsigned sent_ticks = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int          feed_wait = 0;
  int          sink_wait = 0;
  bit          feed_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  two_hand_control_interlock i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one 100 us tick of the interlock
  task automatic advance_interlock(input logic [2:0] buttons, output outcome_t res);
    logic           any_held, both_held, emergency, expired, settled;
    logic [MsW-1:0] nxt;
    int             lim;
    any_held  = buttons[0] | buttons[1];
    both_held = buttons[0] & buttons[1];
    emergency = buttons[2];
    settled   = 1'b0;
    case (ilk_phase)
      PhaseCodeIdle: begin
        ilk_buzz = 1'b0;
        if (any_held) begin
          ilk_phase = PhaseCodeWindow;
          ilk_ms    = '0;
          ilk_pre   = '0;
        end
      end
      PhaseCodeWindow, PhaseCodeRun: begin
        if (ilk_pre == '0) begin
          expired = (ilk_phase == PhaseCodeWindow) ? (ilk_ms >= set_window)
                                                   : (ilk_ms >= set_run || emergency);
          if (expired) begin
            // window timeout or end of run: alarm only while a button is still held
            ilk_phase = any_held ? PhaseCodeAlarm : PhaseCodeIdle;
            ilk_alarm = '0;
            ilk_buzz  = 1'b0;
            ilk_pre   = '0;
            ilk_ms    = '0;
            settled   = 1'b1;
          end else if (ilk_phase == PhaseCodeWindow && both_held) begin
            ilk_phase = PhaseCodeRun;
            ilk_ms    = '0;
            ilk_pre   = '0;
            settled   = 1'b1;
          end else begin
            ilk_ms = ilk_ms + 1'b1;
          end
        end
        if (!settled) begin
          lim = (set_prescale == '0) ? 1 : int'(set_prescale);
          ilk_pre = (int'(ilk_pre) + 1 >= lim) ? '0 : ilk_pre + 1'b1;
        end
      end
      default: begin
        if (!any_held) begin
          ilk_phase = PhaseCodeIdle;
          ilk_buzz  = 1'b0;
          ilk_alarm = '0;
        end else begin
          ilk_buzz = (ilk_alarm < set_alarm_on) ? ~ilk_buzz : 1'b0;
          nxt = ilk_alarm + 1'b1;
          // a zero period lets the count run through the full 16 bits
          if (set_period != '0 && nxt >= set_period) nxt = '0;
          ilk_alarm = nxt;
        end
      end
    endcase
    res.motor  = (ilk_phase == PhaseCodeRun);
    res.lamp   = (ilk_phase == PhaseCodeRun);
    res.buzzer = ilk_buzz;
    res.phase  = ilk_phase;
  endtask

  // tick driver
  always @(posedge clk_i) begin
    outcome_t   res;
    logic       next_valid;
    logic [7:0] next_data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      next_data  = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_interlock(s_axis_tdata[2:0], res);
        outcome_q.push_back(res);
        next_valid = 1'b0;
        feed_wait  = feed_gaps_on ? pick_gap() : 0;
      end
      if (!next_valid) begin
        if (feed_wait > 0) begin
          feed_wait--;
        end else if (tick_q.size() > 0) begin
          next_valid = 1'b1;
          next_data  = {5'b0, tick_q.pop_front()};
        end
      end
      s_axis_tvalid <= next_valid;
      s_axis_tdata  <= next_data;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with nothing expected, tdata %b", $time, m_axis_tdata);
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tdata[0] !== want.motor || m_axis_tdata[1] !== want.lamp ||
              m_axis_tdata[2] !== want.buzzer || m_axis_tdata[4:3] !== want.phase ||
              m_axis_tdata[7:5] !== 3'b000) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: expected motor %0b lamp %0b buzzer %0b phase %0d, got tdata %b",
                       $time, want.motor, want.lamp, want.buzzer, want.phase, m_axis_tdata);
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        sink_wait = HoldCycles;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_wait = sink_stalls_on ? pick_gap() : 0;
      end
    end
  end

  // each pressed bit set with the given chance in percent
  task automatic queue_ticks(input int n, input int one_pct, input int two_pct,
                             input int em_pct);
    for (int i = 0; i < n; i++) begin
      tick_q.push_back({$urandom_range(0, 99) < em_pct, $urandom_range(0, 99) < two_pct,
                        $urandom_range(0, 99) < one_pct});
      sent_ticks++;
    end
  endtask

  // idle, first press, maybe second press, run, held buttons in alarm, release
  task automatic queue_operator_cycle();
    int ticks_per_ms, win_ticks, run_ticks, alarm_ticks;
    bit first_is_one;
    ticks_per_ms = (set_prescale == '0) ? 1 : int'(set_prescale);
    win_ticks    = (int'(set_window) + 1) * ticks_per_ms + 2;
    run_ticks    = (int'(set_run) + 2) * ticks_per_ms + 2;
    alarm_ticks  = (set_period == '0) ? 40 : 2 * int'(set_period) + 4;
    if (win_ticks > 60) win_ticks = 60;
    if (run_ticks > 80) run_ticks = 80;
    if (alarm_ticks > 60) alarm_ticks = 60;
    first_is_one = ($urandom_range(0, 1) != 0);
    queue_ticks($urandom_range(0, 3), 0, 0, 30);
    queue_ticks($urandom_range(1, win_ticks), first_is_one ? 100 : 0,
                first_is_one ? 0 : 100, 10);
    if ($urandom_range(0, 3) != 0) queue_ticks(ticks_per_ms + $urandom_range(0, 2), 100, 100, 0);
    queue_ticks($urandom_range(1, run_ticks), 60, 60, 3);
    if ($urandom_range(0, 1)) queue_ticks($urandom_range(0, alarm_ticks), 100, 50, 30);
    else queue_ticks($urandom_range(0, alarm_ticks), 50, 100, 30);
    queue_ticks($urandom_range(1, 3), 0, 0, 50);
    if ($urandom_range(0, 4) == 0) queue_ticks($urandom_range(1, 6), 50, 50, 50);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // call in step with the rising clock; valid stays high for the next write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegWindowMs:    set_window   = val;
      RegRunMs:       set_run      = val;
      RegMsPrescale:  set_prescale = val[PreW-1:0];
      RegAlarmOn:     set_alarm_on = val;
      RegAlarmPeriod: set_period   = val;
      default: ;
    endcase
  endtask

  initial begin
    static logic [CfgDataW-1:0] win_v[NumSettings] =
      '{16'd0, 16'd4, 16'd1, 16'd0, 16'd2, 16'd65535, 16'd3};
    static logic [CfgDataW-1:0] run_v[NumSettings] =
      '{16'd0, 16'd6, 16'd1, 16'd0, 16'd3, 16'd65535, 16'd5};
    // upper byte set on purpose: only the low byte is the prescaler
    static logic [CfgDataW-1:0] pre_v[NumSettings] =
      '{16'd0, 16'd3, 16'd1, 16'hFF00, 16'd2, 16'd255, 16'd1};
    static logic [CfgDataW-1:0] on_v[NumSettings]  =
      '{16'd0, 16'd3, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd2};
    static logic [CfgDataW-1:0] per_v[NumSettings] =
      '{16'd0, 16'd7, 16'd1, 16'd0, 16'd0, 16'd65535, 16'd4};
    int unsigned target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: emergency ignored in idle, two-hand start, emergency stop into alarm,
    // release to idle, emergency ignored in the window, emergency stop with no button held
    tick_q = '{3'b000, 3'b000, 3'b100, 3'b001, 3'b011, 3'b101, 3'b011, 3'b011, 3'b010,
               3'b000, 3'b010, 3'b111, 3'b100, 3'b110, 3'b011, 3'b011, 3'b001, 3'b111,
               3'b000, 3'b000};
    sent_ticks = 20;

    for (int k = 0; k < NumSettings; k++) begin
      wait_drained();
      feed_gaps_on   = (k != 2);
      sink_stalls_on = (k != 2);
      if (k != 0) begin
        write_reg(RegWindowMs, win_v[k]);
        write_reg(RegRunMs, run_v[k]);
        write_reg(RegMsPrescale, pre_v[k]);
        write_reg(RegAlarmOn, on_v[k]);
        write_reg(RegAlarmPeriod, per_v[k]);
        cfg_valid_i <= 1'b0;
      end
      target = sent_ticks + TicksPerSetting;
      while (sent_ticks < target) queue_operator_cycle();
      // long receiver hold while ticks keep coming
      if (k == 1 || k == 5) hold_requests++;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && outcome_q.size() == 0) begin
      $display("tb_two_hand_control_interlock: PASS");
    end else begin
      $display("tb_two_hand_control_interlock: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_two_hand_control_interlock: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/thci_pkg.sv
sv/two_hand_control_interlock.sv
bench/tb_two_hand_control_interlock.sv
